>>> rtl/mdms_pkg.sv
// Shared types and constants for the motor drive mode supervisor.
// No dependencies; every rtl module refers to it by scoped names.
`timescale 1ns / 1ps

package mdms_pkg;

	// Command codes carried in the input tuser
	localparam logic [2:0] CMD_TICK      = 3'd0;
	localparam logic [2:0] CMD_SET_MODE  = 3'd1;
	localparam logic [2:0] CMD_ENABLE    = 3'd2;
	localparam logic [2:0] CMD_DISABLE   = 3'd3;
	localparam logic [2:0] CMD_START_CAL = 3'd4;
	localparam logic [2:0] CMD_CLR_FAULT = 3'd5;
	localparam logic [2:0] CMD_TRIP      = 3'd6;

	// Operating modes
	localparam logic [2:0] MD_DISABLED  = 3'd0;
	localparam logic [2:0] MD_OPENLOOP  = 3'd1;
	localparam logic [2:0] MD_IMPEDANCE = 3'd5;
	localparam logic [2:0] MD_CALIB     = 3'd6;
	localparam logic [2:0] MD_FAULT     = 3'd7;

	// Fault codes
	localparam logic [3:0] FLT_NONE        = 4'd0;
	localparam logic [3:0] FLT_OVERCURRENT = 4'd1;
	localparam logic [3:0] FLT_CAL_FAIL    = 4'd2;

	// Bridge drive kinds
	localparam logic [2:0] DRV_OFF       = 3'd0;
	localparam logic [2:0] DRV_PRECHARGE = 3'd1;
	localparam logic [2:0] DRV_CALIB     = 3'd2;
	localparam logic [2:0] DRV_OPENLOOP  = 3'd3;
	localparam logic [2:0] DRV_CLOSED    = 3'd4;

	// Calibration results
	localparam logic [1:0] CAL_RUNNING = 2'd0;
	localparam logic [1:0] CAL_DONE    = 2'd1;

	localparam logic [5:0] PRECHARGE_TICKS = 6'd40;
	localparam logic [4:0] SLOW_DIV        = 5'd20;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] requested_mode;
		logic [3:0] trip_code;
		logic       current_saturated;
		logic [3:0] fast_fault_code;
		logic [1:0] cal_result;
	} item_t;

	typedef struct packed {
		logic       status;
		logic [2:0] mode_now;
		logic       enabled_now;
		logic [3:0] fault_now;
		logic [2:0] bridge_drive;
		logic       slow_loop_strobe;
		logic       save_request;
	} result_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       enable;
		logic [3:0] fault;
		logic [5:0] precharge;
		logic [4:0] divider;
	} state_t;

endpackage

>>> rtl/mdms_in_stage.sv
// Input register stage: captures one transaction from the slave side.
// Depends on mdms_pkg for the item type.
`timescale 1ns / 1ps

module mdms_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mdms_pkg::item_t     in_item,
	input  logic                advance,
	output logic                valid_s1,
	output mdms_pkg::item_t     item_s1
);

	logic v_q;

	// Accept when empty or when the held item moves on this cycle
	assign in_ready = !v_q || advance;
	assign valid_s1 = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> rtl/mdms_core.sv
// Supervisor state registers and the single-pass next-state/result logic.
// Depends on mdms_pkg for codes, constants and types.
`timescale 1ns / 1ps

module mdms_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  mdms_pkg::item_t     item_s1,
	input  logic                advance,
	output mdms_pkg::result_t   result
);

	mdms_pkg::state_t st_q;
	mdms_pkg::state_t nxt;
	logic             calibrated_q;
	logic [4:0]       div_inc;
	logic             status;
	logic [2:0]       drive;
	logic             strobe;
	logic             save;

	assign div_inc = st_q.divider + 5'd1;

	always_comb begin
		nxt    = st_q;
		status = 1'b0;
		drive  = mdms_pkg::DRV_OFF;
		strobe = 1'b0;
		save   = 1'b0;
		case (item_s1.mode)
			mdms_pkg::CMD_TICK: begin
				// Protection; a nonzero fast code overrides overcurrent
				if (st_q.enable) begin
					if (item_s1.current_saturated) begin
						nxt.enable = 1'b0;
						nxt.fault  = mdms_pkg::FLT_OVERCURRENT;
						nxt.mode   = mdms_pkg::MD_FAULT;
					end
					if (item_s1.fast_fault_code != mdms_pkg::FLT_NONE) begin
						nxt.enable = 1'b0;
						nxt.fault  = item_s1.fast_fault_code;
						nxt.mode   = mdms_pkg::MD_FAULT;
					end
				end
				if (nxt.mode == mdms_pkg::MD_CALIB) begin
					if (item_s1.cal_result == mdms_pkg::CAL_RUNNING) begin
						drive = nxt.enable ? mdms_pkg::DRV_CALIB : mdms_pkg::DRV_OFF;
					end else begin
						nxt.enable = 1'b0;
						if (item_s1.cal_result == mdms_pkg::CAL_DONE) begin
							save     = 1'b1;
							nxt.mode = mdms_pkg::MD_DISABLED;
						end else begin
							nxt.fault = mdms_pkg::FLT_CAL_FAIL;
							nxt.mode  = mdms_pkg::MD_FAULT;
						end
					end
				end else if (nxt.mode >= mdms_pkg::MD_OPENLOOP &&
					nxt.mode <= mdms_pkg::MD_IMPEDANCE && nxt.enable) begin
					if (st_q.precharge != 6'd0) begin
						nxt.precharge = st_q.precharge - 6'd1;
						drive         = mdms_pkg::DRV_PRECHARGE;
					end else begin
						if (div_inc >= mdms_pkg::SLOW_DIV) begin
							nxt.divider = 5'd0;
							strobe      = 1'b1;
						end else begin
							nxt.divider = div_inc;
						end
						drive = (nxt.mode == mdms_pkg::MD_OPENLOOP) ?
							mdms_pkg::DRV_OPENLOOP : mdms_pkg::DRV_CLOSED;
					end
				end
			end
			mdms_pkg::CMD_SET_MODE: begin
				if (st_q.enable || st_q.mode == mdms_pkg::MD_CALIB ||
					st_q.mode == mdms_pkg::MD_FAULT ||
					item_s1.requested_mode > mdms_pkg::MD_IMPEDANCE) begin
					status = 1'b1;
				end else begin
					nxt.mode = item_s1.requested_mode;
				end
			end
			mdms_pkg::CMD_ENABLE: begin
				if (st_q.mode == mdms_pkg::MD_FAULT || st_q.mode == mdms_pkg::MD_DISABLED ||
					st_q.mode == mdms_pkg::MD_CALIB) begin
					status = 1'b1;
				end else if (st_q.mode != mdms_pkg::MD_OPENLOOP && !calibrated_q) begin
					status = 1'b1;
				end else if (!st_q.enable) begin
					nxt.precharge = mdms_pkg::PRECHARGE_TICKS;
					nxt.enable    = 1'b1;
				end
			end
			mdms_pkg::CMD_DISABLE: begin
				nxt.enable = 1'b0;
			end
			mdms_pkg::CMD_START_CAL: begin
				if (st_q.enable || st_q.mode == mdms_pkg::MD_FAULT ||
					st_q.mode == mdms_pkg::MD_CALIB) begin
					status = 1'b1;
				end else begin
					nxt.mode      = mdms_pkg::MD_CALIB;
					nxt.precharge = 6'd0;
					nxt.enable    = 1'b1;
				end
			end
			mdms_pkg::CMD_CLR_FAULT: begin
				if (st_q.mode == mdms_pkg::MD_FAULT) begin
					nxt.fault = mdms_pkg::FLT_NONE;
					nxt.mode  = mdms_pkg::MD_DISABLED;
				end
			end
			mdms_pkg::CMD_TRIP: begin
				nxt.enable = 1'b0;
				nxt.fault  = item_s1.trip_code;
				nxt.mode   = mdms_pkg::MD_FAULT;
			end
			default: begin
				status = 1'b1;
			end
		endcase
	end

	assign result.status           = status;
	assign result.mode_now         = nxt.mode;
	assign result.enabled_now      = nxt.enable;
	assign result.fault_now        = nxt.fault;
	assign result.bridge_drive     = drive;
	assign result.slow_loop_strobe = strobe;
	assign result.save_request     = save;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calibrated_q <= 1'b0;
		end else if (cfg_wr_en) begin
			calibrated_q <= cfg_wr_data;
		end
	end

endmodule

>>> rtl/mdms_out_reg.sv
// Result register on the master side; holds a transaction while stalled.
// Depends on mdms_pkg for the result type.
`timescale 1ns / 1ps

module mdms_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  mdms_pkg::result_t   result,
	output logic                advance,
	output logic                out_valid,
	input  logic                out_ready,
	output mdms_pkg::result_t   result_s2
);

	logic v_q;

	// Move the stage-1 item when the result slot is free or draining now
	assign advance   = valid_s1 && (!v_q || out_ready);
	assign out_valid = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (advance) begin
			v_q <= 1'b1;
		end else if (out_ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

>>> rtl/motor_drive_mode_supervisor.sv
// Top level of the motor drive mode supervisor.
// Depends on mdms_pkg, mdms_in_stage, mdms_core and mdms_out_reg.
`timescale 1ns / 1ps

// Usage:
//   The slave stream carries one command or control tick per transaction:
//   s_tuser holds the command code, s_tdata its arguments and tick inputs.
//   The master stream returns exactly one status transaction per input,
//   in order: status, mode, enable, latched fault, bridge drive kind,
//   slow-loop strobe and save request.
//   cfg_wr_en/cfg_wr_data write the "calibrated" flag; write it only while
//   no transaction is in flight.
// Pipeline and throughput:
//   A result passes from the input register, which takes it at the accepting
//   edge, into the result register. One transaction per cycle is sustained
//   while m_tready stays high; the rate is set by the single-pass next-state
//   logic around the small state registers, which update when an item enters
//   the result register.
// Reset:
//   arst_n clears mode, enable, fault, precharge count, slow divider, the
//   calibrated flag and both stage valid flags. No clearing pass is needed.
// Stall:
//   When m_tready is low the result register holds; if the input register is
//   empty one more transaction is still taken, then s_tready drops until the
//   result drains.

module motor_drive_mode_supervisor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_wr_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [2:0] mode (command code)
	input  logic [2:0]                     s_tuser,
	// [2:0] requested_mode, [6:3] trip_code, [7] current_saturated,
	// [11:8] fast_fault_code, [13:12] cal_result, [15:14] zero
	input  logic [mdms_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] status, [3:1] mode_now, [4] enabled_now, [8:5] fault_now,
	// [11:9] bridge_drive, [12] slow_loop_strobe, [13] save_request,
	// [15:14] zero
	output logic [mdms_pkg::OUT_DATA_W-1:0] m_tdata
);

	mdms_pkg::item_t   in_item;
	mdms_pkg::item_t   item_s1;
	mdms_pkg::result_t result;
	mdms_pkg::result_t result_s2;
	logic              valid_s1;
	logic              advance;

	// Unpack the slave transaction
	assign in_item.mode              = s_tuser;
	assign in_item.requested_mode    = s_tdata[2:0];
	assign in_item.trip_code         = s_tdata[6:3];
	assign in_item.current_saturated = s_tdata[7];
	assign in_item.fast_fault_code   = s_tdata[11:8];
	assign in_item.cal_result        = s_tdata[13:12];

	mdms_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mdms_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_s1     (item_s1),
		.advance     (advance),
		.result      (result)
	);

	mdms_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result_s2 (result_s2)
	);

	// Pack the master transaction
	assign m_tdata = {2'b00,
		result_s2.save_request,
		result_s2.slow_loop_strobe,
		result_s2.bridge_drive,
		result_s2.fault_now,
		result_s2.enabled_now,
		result_s2.mode_now,
		result_s2.status};

	// The bridge is never enabled while disabled or faulted
	a_enable_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.enabled_now |->
			result_s2.mode_now != mdms_pkg::MD_DISABLED &&
			result_s2.mode_now != mdms_pkg::MD_FAULT)
		else $error("bridge enabled in disabled or fault mode");

	// Any drive other than off needs the bridge enabled
	a_drive_enable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.bridge_drive != mdms_pkg::DRV_OFF |->
			result_s2.enabled_now)
		else $error("bridge driven while not enabled");

	// Save request only after calibration ends cleanly
	a_save: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.save_request |->
			result_s2.mode_now == mdms_pkg::MD_DISABLED && !result_s2.enabled_now)
		else $error("save request outside successful calibration end");

	// Slow-loop strobe only while the loops run
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.slow_loop_strobe |->
			result_s2.bridge_drive == mdms_pkg::DRV_OPENLOOP ||
			result_s2.bridge_drive == mdms_pkg::DRV_CLOSED)
		else $error("slow-loop strobe without active drive");

endmodule

>>> tb/sv/mdms_status_checker.sv
// Status checker for the motor drive mode supervisor testbench.
// Depends on mdms_pkg; watches the command, status and config ports of the block.
`timescale 1ns / 1ps

module mdms_status_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic                            cfg_wr_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [2:0]                      s_tuser,
	input  logic [mdms_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [mdms_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                              status_pending,
	output int                              mismatch_count
);
	import mdms_pkg::*;

	localparam logic STATUS_REFUSED = 1'b1;

	state_t  sup;
	logic    calibrated_copy;
	result_t status_due_q[$];

	initial mismatch_count = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch: %s got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input int got, input int want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic latch_trip(input logic [3:0] code);
		sup.enable = 1'b0;
		sup.fault  = code;
		sup.mode   = MD_FAULT;
	endtask

	// Advance the supervisor state by one command or tick and form its status.
	task automatic predict_status(input item_t it, output result_t res);
		res = '0;
		case (it.mode)
		CMD_TICK: begin
			if (sup.enable) begin
				if (it.current_saturated)
					latch_trip(FLT_OVERCURRENT);
				if (it.fast_fault_code != FLT_NONE)
					latch_trip(it.fast_fault_code);
			end
			if (sup.mode == MD_CALIB) begin
				if (it.cal_result == CAL_RUNNING) begin
					res.bridge_drive = sup.enable ? DRV_CALIB : DRV_OFF;
				end else begin
					sup.enable = 1'b0;
					if (it.cal_result == CAL_DONE) begin
						res.save_request = 1'b1;
						sup.mode = MD_DISABLED;
					end else begin
						sup.fault = FLT_CAL_FAIL;
						sup.mode  = MD_FAULT;
					end
				end
			end else if (sup.mode >= MD_OPENLOOP && sup.mode <= MD_IMPEDANCE && sup.enable) begin
				if (sup.precharge != '0) begin
					sup.precharge = sup.precharge - 6'd1;
					res.bridge_drive = DRV_PRECHARGE;
				end else begin
					sup.divider = sup.divider + 5'd1;
					if (sup.divider >= SLOW_DIV) begin
						sup.divider = '0;
						res.slow_loop_strobe = 1'b1;
					end
					res.bridge_drive = (sup.mode == MD_OPENLOOP) ? DRV_OPENLOOP : DRV_CLOSED;
				end
			end
		end
		CMD_SET_MODE: begin
			if (sup.enable || sup.mode == MD_CALIB || sup.mode == MD_FAULT ||
			    it.requested_mode > MD_IMPEDANCE)
				res.status = STATUS_REFUSED;
			else
				sup.mode = it.requested_mode;
		end
		CMD_ENABLE: begin
			if (sup.mode == MD_FAULT || sup.mode == MD_DISABLED || sup.mode == MD_CALIB)
				res.status = STATUS_REFUSED;
			else if (sup.mode != MD_OPENLOOP && !calibrated_copy)
				res.status = STATUS_REFUSED;
			else if (!sup.enable) begin
				sup.precharge = PRECHARGE_TICKS;
				sup.enable    = 1'b1;
			end
		end
		CMD_DISABLE: sup.enable = 1'b0;
		CMD_START_CAL: begin
			if (sup.enable || sup.mode == MD_FAULT || sup.mode == MD_CALIB) begin
				res.status = STATUS_REFUSED;
			end else begin
				sup.mode      = MD_CALIB;
				sup.precharge = '0;
				sup.enable    = 1'b1;
			end
		end
		CMD_CLR_FAULT: begin
			if (sup.mode == MD_FAULT) begin
				sup.fault = FLT_NONE;
				sup.mode  = MD_DISABLED;
			end
		end
		CMD_TRIP: latch_trip(it.trip_code);
		default: res.status = STATUS_REFUSED;
		endcase
		res.mode_now    = sup.mode;
		res.enabled_now = sup.enable;
		res.fault_now   = sup.fault;
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t   cmd_item;
		result_t due;
		if (!arst_n) begin
			sup             = '0;
			calibrated_copy = 1'b0;
			status_due_q.delete();
			status_pending <= 0;
		end else begin
			if (cfg_wr_en)
				calibrated_copy = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				cmd_item.mode              = s_tuser;
				cmd_item.requested_mode    = s_tdata[2:0];
				cmd_item.trip_code         = s_tdata[6:3];
				cmd_item.current_saturated = s_tdata[7];
				cmd_item.fast_fault_code   = s_tdata[11:8];
				cmd_item.cal_result        = s_tdata[13:12];
				predict_status(cmd_item, due);
				status_due_q.push_back(due);
			end
			if (m_tvalid && m_tready) begin
				if (status_due_q.size() == 0) begin
					report_mismatch("status with none outstanding", int'(m_tdata), 0);
				end else begin
					due = status_due_q.pop_front();
					check_field("status", int'(m_tdata[0]), int'(due.status));
					check_field("mode_now", int'(m_tdata[3:1]), int'(due.mode_now));
					check_field("enabled_now", int'(m_tdata[4]), int'(due.enabled_now));
					check_field("fault_now", int'(m_tdata[8:5]), int'(due.fault_now));
					check_field("bridge_drive", int'(m_tdata[11:9]),
						int'(due.bridge_drive));
					check_field("slow_loop_strobe", int'(m_tdata[12]),
						int'(due.slow_loop_strobe));
					check_field("save_request", int'(m_tdata[13]),
						int'(due.save_request));
				end
			end
			status_pending <= status_due_q.size();
		end
	end

endmodule

>>> tb/sv/motor_drive_mode_supervisor_tb.sv
// Testbench top for the motor drive mode supervisor: clock, reset, stimulus, verdict.
// Depends on mdms_pkg, motor_drive_mode_supervisor and mdms_status_checker.
`timescale 1ns / 1ps

module motor_drive_mode_supervisor_tb;
	import mdms_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [2:0] CMD_UNKNOWN = 3'd7;
	localparam logic [2:0] MD_TORQUE   = 3'd2;
	localparam logic [2:0] MD_SPEED    = 3'd3;
	localparam logic [1:0] CAL_FAILED  = 2'd2;
	localparam logic [1:0] CAL_UNUSED  = 2'd3;

	localparam int RANDOM_ITEMS = 900;
	localparam int PHASES       = 5;
	localparam int CYCLE_LIMIT  = 400000;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic                  cfg_wr_data = 1'b0;
	logic                  s_tvalid    = 1'b0;
	logic [2:0]            s_tuser     = '0;
	logic [IN_DATA_W-1:0]  s_tdata     = '0;
	logic                  m_tready    = 1'b0;
	wire                   s_tready;
	wire                   m_tvalid;
	wire  [OUT_DATA_W-1:0] m_tdata;

	int status_pending;
	int mismatch_count;
	int cycle_count  = 0;
	int items_issued = 0;
	bit gapless      = 1'b0;

	motor_drive_mode_supervisor u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	mdms_status_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tuser        (s_tuser),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.status_pending (status_pending),
		.mismatch_count (mismatch_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold reset at the start, then release it for good.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Bound the run; a lost or stuck status ends up here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Stall the status side: mostly short ready runs and short stalls, now and
	// then a long stall, and long runs with no stall at all.
	initial begin
		int run_len;
		int stall_len;
		int pick;
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
			                                      : $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				stall_len = $urandom_range(1, 3);
			else if (pick < 95)
				stall_len = $urandom_range(4, 10);
			else
				stall_len = $urandom_range(20, 40);
			m_tready <= 1'b0;
			repeat (stall_len) @(posedge clk);
		end
	end

	// Idle length after a command transaction; zero inside a gapless stretch.
	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (gapless || pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Present one command, hold it until taken, then idle for a random gap.
	// Valid stays high straight into the next command when the gap is zero.
	task automatic issue(input logic [2:0] cmd, input logic [2:0] req, input logic [3:0] tcode,
	                     input logic sat, input logic [3:0] ffc, input logic [1:0] cres);
		int gap;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, cres, ffc, sat, tcode, req};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		items_issued++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Command with every argument field random
	task automatic issue_any(input logic [2:0] cmd);
		issue(cmd, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
		      1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
		      2'($urandom_range(0, 3)));
	endtask

	// Tick with the given protection and calibration inputs; the rest random
	task automatic issue_tick(input logic sat, input logic [3:0] ffc, input logic [1:0] cres);
		issue(CMD_TICK, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), sat, ffc, cres);
	endtask

	task automatic issue_noise();
		issue_any(3'($urandom_range(0, 7)));
	endtask

	// Drop valid and wait until every status has come back and the pipe is empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (status_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_calibrated(input logic value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Bring the drive back to a known idle mode: stop the bridge, end any
	// calibration still in progress, and clear a latched fault.
	task automatic settle_to_idle();
		issue_any(CMD_DISABLE);
		issue_tick(1'b0, 4'd0, CAL_DONE);
		issue_any(CMD_CLR_FAULT);
	endtask

	// Select a mode, enable, and run a stream of mostly clean ticks, at times long
	// enough to get through precharge and into the slow-loop strobes.
	task automatic run_drive_sequence();
		logic [2:0] target;
		int         n_ticks;
		int         pick;
		settle_to_idle();
		target = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(MD_OPENLOOP, MD_IMPEDANCE))
		                                    : 3'($urandom_range(0, 7));
		issue(CMD_SET_MODE, target, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
		      4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
		issue_any(CMD_ENABLE);
		n_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 60);
		repeat (n_ticks) begin
			pick = $urandom_range(0, 99);
			if (pick < 94)
				issue_tick(1'b0, 4'd0, 2'($urandom_range(0, 3)));
			else if (pick < 96)
				issue_tick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
				           2'($urandom_range(0, 3)));
			else
				issue_noise();
		end
		case ($urandom_range(0, 3))
		0: issue_any(CMD_DISABLE);
		1: issue_any(CMD_TRIP);
		2: issue_tick(1'b1, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
		default: ;
		endcase
	endtask

	// Start calibration, let it run a while, then finish it one way or another.
	task automatic run_calibration_sequence();
		int         pick;
		logic [1:0] outcome;
		settle_to_idle();
		if ($urandom_range(0, 1))
			issue_any(CMD_SET_MODE);
		issue_any(CMD_START_CAL);
		repeat ($urandom_range(0, 15)) begin
			pick = $urandom_range(0, 99);
			if (pick < 85)
				issue_tick(1'b0, 4'd0, CAL_RUNNING);
			else if (pick < 92)
				issue_any(CMD_DISABLE);
			else
				issue_tick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), CAL_RUNNING);
		end
		pick = $urandom_range(0, 99);
		outcome = (pick < 60) ? CAL_DONE : (pick < 85) ? CAL_FAILED : CAL_UNUSED;
		issue_tick(1'b0, 4'd0, outcome);
	endtask

	initial begin
		int   phase_end;
		logic phase_cal [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		int   pick;

		wait (arst_n);
		@(posedge clk);

		// Directed part with calibrated at its reset value of zero.
		// Tick while idle with every protection input raised: no effect.
		issue(CMD_TICK, 3'd7, 4'd15, 1'b1, 4'd15, CAL_UNUSED);
		issue(CMD_UNKNOWN, 3'd0, 4'd0, 1'b0, 4'd0, 2'd0);
		issue_any(CMD_ENABLE);                                 // refused in disabled mode
		issue(CMD_SET_MODE, 3'd7, 4'd0, 1'b0, 4'd0, 2'd0);     // out-of-range mode
		issue(CMD_SET_MODE, MD_TORQUE, 4'd15, 1'b1, 4'd15, 2'd3);
		issue_any(CMD_ENABLE);                                 // closed loop needs calibration
		issue(CMD_SET_MODE, MD_OPENLOOP, 4'd0, 1'b0, 4'd0, 2'd0);
		issue_any(CMD_ENABLE);
		issue_any(CMD_ENABLE);                                 // already enabled: no change
		issue(CMD_SET_MODE, MD_SPEED, 4'd0, 1'b0, 4'd0, 2'd0); // refused while enabled
		issue_tick(1'b1, 4'd0, CAL_RUNNING);                   // overcurrent trip
		issue_any(CMD_START_CAL);                              // refused in fault
		issue_any(CMD_CLR_FAULT);
		issue_any(CMD_START_CAL);
		issue_tick(1'b0, 4'd0, CAL_RUNNING);                   // calibration drive
		issue_any(CMD_DISABLE);
		issue_tick(1'b0, 4'd0, CAL_RUNNING);                   // calibrating with bridge off
		issue_tick(1'b0, 4'd0, CAL_DONE);                      // save request
		issue_any(CMD_START_CAL);
		issue_tick(1'b0, 4'd0, CAL_UNUSED);                    // unused result fails
		issue_any(CMD_CLR_FAULT);
		issue(CMD_SET_MODE, MD_OPENLOOP, 4'd0, 1'b0, 4'd0, 2'd0);
		issue_any(CMD_ENABLE);
		issue_tick(1'b1, 4'd9, CAL_RUNNING);                   // protection code overrides overcurrent
		issue(CMD_TRIP, 3'd0, 4'd0, 1'b0, 4'd0, 2'd0);         // trip with code zero
		issue_any(CMD_CLR_FAULT);

		// Random part: alternate the calibrated flag between phases.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_calibrated(phase_cal[ph]);
			phase_end = items_issued + RANDOM_ITEMS / PHASES;
			while (items_issued < phase_end) begin
				gapless = ($urandom_range(0, 4) == 0);
				pick = $urandom_range(0, 9);
				if (pick < 5)
					run_drive_sequence();
				else if (pick < 7)
					run_calibration_sequence();
				else
					repeat ($urandom_range(1, 8)) issue_noise();
			end
		end

		drain();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/mdms_pkg.sv
rtl/mdms_in_stage.sv
rtl/mdms_core.sv
rtl/mdms_out_reg.sv
rtl/motor_drive_mode_supervisor.sv
tb/sv/mdms_status_checker.sv
tb/sv/motor_drive_mode_supervisor_tb.sv
